FILE: src/itda_pkg.sv
// Package for the integer to decimal ASCII converter.
// Shared constants, character codes and the sequencer state type; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itda_pkg;

  // Default width of the signed input value
  localparam int VALUE_BITS_DEF = 32;

  // Width of one output character
  localparam int CHAR_BITS = 7;

  // Bits of one BCD digit
  localparam int BCD_BITS = 4;

  // Character codes
  localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_BITS-1:0] ASCII_NINE  = 7'd57;
  localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 7'd45;

  // Correction threshold of the shift-and-add-3 step
  localparam logic [BCD_BITS-1:0] BCD_FIVE  = 4'd5;
  localparam logic [BCD_BITS-1:0] BCD_THREE = 4'd3;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_TRIM = 4'b0100,
    S_EMIT = 4'b1000
  } itda_state_t;

endpackage : itda_pkg

`default_nettype wire

FILE: src/itda_ifs.sv
// Handshake interfaces of the integer to decimal ASCII converter.
// Input channel carries one signed value, output channel one character; uses itda_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface itda_in_if
  import itda_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface : itda_in_if

interface itda_out_if
  import itda_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] char_code;
  logic                 is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface : itda_out_if

`default_nettype wire

FILE: src/integer_to_decimal_ascii.sv
// Top level of the integer to decimal ASCII converter.
// Depends on itda_pkg and the channel interfaces in itda_ifs.sv.
`timescale 1ns / 1ps
`default_nettype none

// Converts one signed VALUE_BITS-bit integer into its decimal text, one ASCII
// character per output item, most significant first, with a leading '-' for
// negative values, no leading zeros and is_last set on the final character.
// The most negative value prints as magnitude 2^(VALUE_BITS-1). One value
// takes one cycle to accept and is then converted by shift-and-add-3, one
// magnitude bit per step through one shared BCD correction unit. Leading zeros
// are then stripped one digit at a time, and the characters are emitted one per
// output item; an output stall holds the emission until the character is taken.
// The input is not ready until the last character of the previous value has
// been loaded into the output register.

module integer_to_decimal_ascii
  import itda_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  itda_in_if.sink      in,
  itda_out_if.source   out
);

  // Decimal digits of 2^(VALUE_BITS-1): floor((VALUE_BITS-1)*log10(2)) + 1
  localparam int DIGITS = (((VALUE_BITS - 1) * 1233) >> 12) + 1;
  localparam int BW     = DIGITS * BCD_BITS;
  localparam int SW     = $clog2(VALUE_BITS + 1);
  localparam int NW     = $clog2(DIGITS + 1);

  itda_state_t           state;
  logic [VALUE_BITS-1:0] mag;
  logic [BW-1:0]         bcd;
  logic [BW-1:0]         bcd_adj;
  logic [SW-1:0]         step;
  logic [NW-1:0]         ndig;
  logic                  neg;
  logic                  sign_pending;

  logic                  out_valid;
  logic [CHAR_BITS-1:0]  out_char;
  logic                  out_last;

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag_in;
  logic [BCD_BITS-1:0]   top_digit;
  logic                  slot_free;

  // Take magnitude of the incoming value
  assign raw       = $unsigned(in.value);
  assign mag_in    = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
  assign top_digit = bcd[BW-1 -: BCD_BITS];
  assign slot_free = !out_valid || out.ready;

  assign in.ready      = (state == S_IDLE);
  assign out.valid     = out_valid;
  assign out.char_code = out_char;
  assign out.is_last   = out_last;

  // Add 3 to every BCD digit of five or more
  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd[d*BCD_BITS +: BCD_BITS] >= BCD_FIVE) begin
        bcd_adj[d*BCD_BITS +: BCD_BITS] = bcd[d*BCD_BITS +: BCD_BITS] + BCD_THREE;
      end else begin
        bcd_adj[d*BCD_BITS +: BCD_BITS] = bcd[d*BCD_BITS +: BCD_BITS];
      end
    end
  end

  // Sequencer: accept, convert, strip leading zeros, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      sign_pending <= 1'b0;
      neg          <= 1'b0;
      step         <= '0;
      ndig         <= '0;
    end else begin
      // Drop the held character once taken; while emitting the next one loads instead
      if (out_valid && out.ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in.valid) begin
            mag          <= mag_in;
            bcd          <= '0;
            neg          <= raw[VALUE_BITS-1];
            sign_pending <= raw[VALUE_BITS-1];
            step         <= SW'(VALUE_BITS);
            state        <= S_CONV;
          end
        end
        S_CONV: begin
          // Shift one magnitude bit into the corrected BCD register
          bcd  <= {bcd_adj[BW-2:0], mag[VALUE_BITS-1]};
          mag  <= {mag[VALUE_BITS-2:0], 1'b0};
          step <= step - 1'b1;
          if (step == SW'(1)) begin
            ndig  <= NW'(DIGITS);
            state <= S_TRIM;
          end
        end
        S_TRIM: begin
          if (top_digit == '0 && ndig != NW'(1)) begin
            bcd  <= {bcd[BW-BCD_BITS-1:0], {BCD_BITS{1'b0}}};
            ndig <= ndig - 1'b1;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            if (sign_pending) begin
              out_char     <= ASCII_MINUS;
              out_last     <= 1'b0;
              sign_pending <= 1'b0;
            end else begin
              out_char <= ASCII_ZERO + CHAR_BITS'(top_digit);
              out_last <= (ndig == NW'(1));
              bcd      <= {bcd[BW-BCD_BITS-1:0], {BCD_BITS{1'b0}}};
              ndig     <= ndig - 1'b1;
              if (ndig == NW'(1)) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Digit count stays in range while digits remain to strip or emit
  a_ndig_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_TRIM || state == S_EMIT) |-> (ndig != '0 && ndig <= NW'(DIGITS)))
    else $error("digit count out of range");

  // Conversion never runs with an exhausted step counter
  a_step_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_CONV) |-> (step != '0))
    else $error("conversion step counter exhausted");

  // A minus sign only appears for a negative value, and never last
  a_minus_neg: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_char == ASCII_MINUS) |-> (neg && !out_last))
    else $error("minus sign on non-negative value or as last character");

  // Every other character is a decimal digit
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_char != ASCII_MINUS) |->
      (out_char >= ASCII_ZERO && out_char <= ASCII_NINE))
    else $error("character is not a decimal digit");

  // Sign is still pending when leading-zero stripping starts for a negative value
  a_sign_first: assert property (@(posedge clk) disable iff (rst)
    (state == S_TRIM && $past(state) == S_CONV) |-> (sign_pending == neg))
    else $error("sign flag lost before emission");

endmodule : integer_to_decimal_ascii

`default_nettype wire

FILE: verif/itda_text_checker.sv
// Checker for the integer to decimal ASCII converter: predicts and compares characters.
// Watches both channels of the block; uses itda_pkg for widths and character codes.
`timescale 1ns / 1ps

module itda_text_checker
  import itda_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [CHAR_BITS-1:0]  char_code,
  input  logic                  is_last,
  input  logic                  end_of_run,
  output int                    fail_count,
  output int                    pending,
  output int                    values_seen,
  output int                    negatives_seen,
  output int                    zeros_seen,
  output int                    chars_seen
);

  // One expected character, with the value it came from for messages
  typedef struct {
    logic [CHAR_BITS-1:0] char_code;
    logic                 is_last;
    longint               origin;
  } text_char_t;

  text_char_t expected_text[$];

  initial begin
    fail_count     = 0;
    pending        = 0;
    values_seen    = 0;
    negatives_seen = 0;
    zeros_seen     = 0;
    chars_seen     = 0;
  end

  task automatic report_mismatch(input string what, input logic [CHAR_BITS-1:0] got,
                                 input logic [CHAR_BITS-1:0] want, input longint origin);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d (value %0d)",
             $time, what, got, want, origin);
    fail_count++;
  endtask

  // Queue the decimal text of one value, most significant character first
  function automatic void predict_text(input logic [VALUE_BITS-1:0] raw);
    logic [VALUE_BITS-1:0] mag;
    longint unsigned       rest;
    logic [3:0]            digits[$];
    text_char_t            c;
    logic                  negative;
    longint                origin;

    negative = raw[VALUE_BITS-1];
    origin   = longint'($signed(raw));
    // two's complement negation; the most negative value yields 2^(VALUE_BITS-1)
    mag      = negative ? (~raw + 1'b1) : raw;
    rest     = longint'(mag);
    if (VALUE_BITS < 64) rest = rest & ((64'd1 << VALUE_BITS) - 1);
    do begin
      digits.push_front(4'(rest % 10));
      rest = rest / 10;
    end while (rest != 0);

    c.origin = origin;
    if (negative) begin
      c.char_code = ASCII_MINUS;
      c.is_last   = 1'b0;
      expected_text.push_back(c);
    end
    foreach (digits[i]) begin
      c.char_code = ASCII_ZERO + CHAR_BITS'(digits[i]);
      c.is_last   = (i == digits.size() - 1);
      expected_text.push_back(c);
    end
  endfunction

  // Check each accepted character, then queue the text of each accepted value
  always @(posedge clk) begin : watch
    text_char_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        chars_seen++;
        if (expected_text.size() == 0) begin
          report_mismatch("character with nothing pending", char_code, 'x, 0);
        end else begin
          want = expected_text.pop_front();
          if (char_code !== want.char_code)
            report_mismatch("char_code", char_code, want.char_code, want.origin);
          if (is_last !== want.is_last)
            report_mismatch("is_last", is_last, want.is_last, want.origin);
        end
      end
      if (in_valid && in_ready) begin
        predict_text(in_value);
        values_seen++;
        if (in_value[VALUE_BITS-1]) negatives_seen++;
        if (in_value == '0) zeros_seen++;
      end
      // drop anything still owed at the end, counting each as a failure
      if (end_of_run) begin
        while (expected_text.size() != 0) begin
          want = expected_text.pop_front();
          report_mismatch("character never emitted", 'x, want.char_code, want.origin);
        end
      end
    end
    pending = expected_text.size();
  end

endmodule : itda_text_checker

FILE: verif/integer_to_decimal_ascii_tb.sv
// Testbench top for the integer to decimal ASCII converter: stimulus, flow control, verdict.
// Depends on itda_pkg, the channel interfaces, the block itself and itda_text_checker.
`timescale 1ns / 1ps

module integer_to_decimal_ascii_tb;
  import itda_pkg::*;

  localparam int VALUE_BITS   = VALUE_BITS_DEF;
  localparam int RANDOM_ITEMS = 350;
  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst;
  logic end_of_run;

  int fail_count, pending, values_seen, negatives_seen, zeros_seen, chars_seen;
  int rx_cycle, hold_left, stall_left, holdoffs, idle_cycles;

  longint plan[$];
  longint directed_set [0:23];

  itda_in_if #(.VALUE_BITS(VALUE_BITS)) in_ch ();
  itda_out_if                           out_ch ();

  integer_to_decimal_ascii #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk (clk),
    .rst (rst),
    .in  (in_ch),
    .out (out_ch)
  );

  itda_text_checker #(.VALUE_BITS(VALUE_BITS)) checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_value       (in_ch.value),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .char_code      (out_ch.char_code),
    .is_last        (out_ch.is_last),
    .end_of_run     (end_of_run),
    .fail_count     (fail_count),
    .pending        (pending),
    .values_seen    (values_seen),
    .negatives_seen (negatives_seen),
    .zeros_seen     (zeros_seen),
    .chars_seen     (chars_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Random value, half the time with a chosen number of digits so every length turns up
  function automatic longint random_value();
    longint lo, hi, p, v;
    int     n;
    case ($urandom_range(0, 5))
      0: v = longint'($signed($urandom));
      1: v = longint'($urandom_range(0, 30)) - 15;
      2: begin
        // near a power of ten, where the digit count changes
        p = 1;
        repeat ($urandom_range(0, 9)) p = p * 10;
        v = p + longint'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: begin
        n  = $urandom_range(1, 10);
        lo = 1;
        repeat (n - 1) lo = lo * 10;
        hi = (n == 10) ? 64'd2147483647 : lo * 10 - 1;
        if (n == 1) lo = 0;
        v = lo + longint'($urandom_range(0, int'(hi - lo)));
        if ($urandom_range(0, 1) == 1) v = -v - longint'($urandom_range(0, 1));
      end
    endcase
    return v;
  endfunction

  // Offer one value and hold it until the block takes it
  task automatic offer_value(input longint v);
    in_ch.valid <= 1'b1;
    in_ch.value <= VALUE_BITS'(v);
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
  endtask

  // Receiver: rotate through four stall patterns, with periodic long hold-offs
  always @(posedge clk) begin : receiver
    logic take;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 6000 == 3000) begin
        hold_left = HOLD_CYCLES;
        holdoffs++;
      end
      if (hold_left > 0) begin
        take = 1'b0;
        hold_left--;
      end else begin
        case ((rx_cycle / 500) % 4)
          0: take = 1'b1;
          1: take = ($urandom_range(0, 3) != 0);
          2: take = (rx_cycle % 3 == 0);
          default: begin
            if (stall_left > 0) begin
              take = 1'b0;
              stall_left--;
            end else begin
              take = 1'b1;
              if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 30);
            end
          end
        endcase
      end
      out_ch.ready <= take;
    end
  end

  // Watchdog: end the run if no item moves for too long
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles, %0d characters pending",
                 IDLE_LIMIT, pending);
        $display("integer_to_decimal_ascii verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int burst, gap, idx;
    rst          <= 1'b1;
    end_of_run   <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.value  <= '0;

    // extremes, digit-count boundaries and alternating bit patterns
    directed_set = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 2147483647, -64'sd2147483648,
                     -2147483647, 2147483646, 1000000000, -1000000000, 999999999,
                     -999999999, 1234567890, -1234567890, 64'sh55555555,
                     -64'sh55555556, 1000000007, 7};
    foreach (directed_set[i]) plan.push_back(directed_set[i]);
    repeat (RANDOM_ITEMS) plan.push_back(random_value());

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // drive the plan in bursts, sometimes long ones with no idling
    idx = 0;
    while (idx < plan.size()) begin
      burst = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
      while (burst > 0 && idx < plan.size()) begin
        offer_value(plan[idx]);
        idx++;
        burst--;
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        in_ch.value <= VALUE_BITS'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;

    // drain, then allow for any late character
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    end_of_run <= 1'b1;
    @(negedge clk);
    @(negedge clk);

    $display("Converted %0d values (%0d negative, %0d zero) into %0d checked characters.",
             values_seen, negatives_seen, zeros_seen, chars_seen);
    $display("Receiver held off %0d times for %0d cycles while values kept arriving.",
             holdoffs, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("integer_to_decimal_ascii verification clean");
    end else begin
      $display("integer_to_decimal_ascii verification failed");
    end
    $finish;
  end

endmodule : integer_to_decimal_ascii_tb
